// ===== hdl/rrr_pkg.sv =====
// ----------------------------------------------------------------------------
// rrr_pkg: shared types and codes of the round-robin ready ring
// Operation codes, status codes and the result record that the sequencer
// hands to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rrr_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NEXT   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef struct packed {
        logic [3:0] chosen;
        logic       empty;
        logic [1:0] status;
    } rrr_res_t;

endpackage

`default_nettype wire

// ===== hdl/rrr_ram.sv =====
// ----------------------------------------------------------------------------
// rrr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/rrr_seq.sv =====
// ----------------------------------------------------------------------------
// rrr_seq: ring sequencer
// Holds tail, membership and empty flag, and drives the next-task table
// through its single read port to link, unlink and walk the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module rrr_seq
    import rrr_pkg::*;
#(
    parameter int TASKS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            idle,
    input  wire logic [1:0] op,
    input  wire logic [7:0] task_req,
    input  wire logic       res_free,
    output logic            res_valid,
    output rrr_res_t        res
);

    localparam int IW = $clog2(TASKS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ADD_RD  = 3'd1;
    localparam logic [2:0] S_ADD_WR  = 3'd2;
    localparam logic [2:0] S_RM_RD   = 3'd3;
    localparam logic [2:0] S_RM_WALK = 3'd4;
    localparam logic [2:0] S_NX_RD   = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [TASKS-1:0] mask_reg, mask_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [IW-1:0]    req_reg, req_next;
    logic [IW-1:0]    succ_reg, succ_next;
    logic [IW-1:0]    pred_reg, pred_next;
    logic [1:0]       status_reg, status_next;

    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [IW-1:0]    wr_data;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    rd_data;

    logic [IW-1:0]    req_idx;
    logic             in_range;

    assign req_idx  = IW'(task_req);
    assign in_range = {1'b0, task_req} < 9'(TASKS);

    rrr_ram #(
        .WIDTH (IW),
        .DEPTH (TASKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        mask_next   = mask_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        req_next    = req_reg;
        succ_next   = succ_reg;
        pred_next   = pred_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = req_reg;
        wr_data     = rd_data;
        rd_addr     = tail_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = req_idx;
                    status_next = ST_DONE;
                    state_next  = S_DONE;
                    unique case (op)
                        OP_CLEAR:
                        begin
                            mask_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        OP_ADD:
                        begin
                            if (!in_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (mask_reg[req_idx])
                            begin
                                status_next = ST_PRESENT;
                            end
                            else if (empty_reg)
                            begin
                                // first task links to itself
                                wr_en              = 1'b1;
                                wr_addr            = req_idx;
                                wr_data            = req_idx;
                                tail_next          = req_idx;
                                empty_next         = 1'b0;
                                mask_next[req_idx] = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = tail_reg;
                                state_next = S_ADD_RD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!in_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (empty_reg || !mask_reg[req_idx])
                            begin
                                status_next = ST_ABSENT;
                            end
                            else
                            begin
                                mask_next[req_idx] = 1'b0;
                                rd_addr            = req_idx;
                                state_next         = S_RM_RD;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (empty_reg)
                            begin
                                status_next = ST_ABSENT;
                            end
                            else
                            begin
                                rd_addr    = tail_reg;
                                state_next = S_NX_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                // new task inherits the tail's successor
                wr_en      = 1'b1;
                wr_addr    = req_reg;
                wr_data    = rd_data;
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                wr_en              = 1'b1;
                wr_addr            = tail_reg;
                wr_data            = req_reg;
                tail_next          = req_reg;
                mask_next[req_reg] = 1'b1;
                state_next         = S_DONE;
            end
            S_RM_RD:
            begin
                succ_next = rd_data;
                if (rd_data == req_reg)
                begin
                    // last task leaves
                    tail_next  = '0;
                    empty_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    pred_next  = tail_reg;
                    rd_addr    = tail_reg;
                    state_next = S_RM_WALK;
                end
            end
            S_RM_WALK:
            begin
                if (rd_data == req_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pred_reg;
                    wr_data = succ_reg;
                    if (tail_reg == req_reg)
                    begin
                        tail_next = pred_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    // advance one link
                    pred_next = rd_data;
                    rd_addr   = rd_data;
                end
            end
            S_NX_RD:
            begin
                tail_next  = rd_data;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mask_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        succ_reg   <= succ_next;
        pred_reg   <= pred_next;
        status_reg <= status_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.chosen = empty_reg ? 4'd0 : 4'(tail_reg);
    assign res.empty  = empty_reg;
    assign res.status = status_reg;

endmodule

`default_nettype wire

// ===== hdl/round_robin_ready_ring_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_ready_ring_unit: round-robin ready ring
// Ready tasks kept as a circular linked ring; clear, add, remove, next.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op and task_req. Each accepted
//   beat produces exactly one output beat (out_valid/out_ready) carrying
//   chosen_task, ring_empty and status.
//   Steps per input beat:
//     clear, failed ops, add to an empty ring ........ done from idle
//     next, remove of the last task ................... one table read
//     add to a non-empty ring ......................... read, two writes
//     remove .......................................... read, ring walk, write
//   The remove walk follows the ring one link per cycle through the single
//   read port of the next-task table, which sets the worst case. One item is
//   in flight at a time; in_ready is high only while the sequencer is idle.
//   The output register lets a new beat be accepted while a result waits.
//   If the receiver stalls with a result still held, the sequencer holds its
//   finished result until the output register frees.
//   Reset empties the ring (no members, tail 0); table contents are not
//   cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_ready_ring_unit
    import rrr_pkg::*;
#(
    parameter int TASKS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] op,
    input  wire logic [7:0] task_req,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [3:0]      chosen_task,
    output logic            ring_empty,
    output logic [1:0]      status
);

    logic     seq_idle;
    logic     res_valid;
    logic     res_free;
    rrr_res_t res;

    logic     out_valid_reg, out_valid_next;
    rrr_res_t out_reg;

    assign in_ready = seq_idle;
    assign res_free = !out_valid_reg || out_ready;

    rrr_seq #(
        .TASKS (TASKS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .idle      (seq_idle),
        .op        (op),
        .task_req  (task_req),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_free)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign chosen_task = out_reg.chosen;
    assign ring_empty  = out_reg.empty;
    assign status      = out_reg.status;

endmodule

`default_nettype wire

// ===== hdl/rrr_checker.sv =====
// ----------------------------------------------------------------------------
// rrr_checker: port-level checks of the ready ring
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module rrr_checker
    import rrr_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [1:0] op,
    input wire logic [7:0] task_req,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [3:0] chosen_task,
    input wire logic       ring_empty,
    input wire logic [1:0] status
);

    // hold a waiting input beat
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(op) && $stable(task_req))
        else $error("waiting input beat changed");

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(chosen_task)
            && $stable(ring_empty) && $stable(status))
        else $error("stalled result beat changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ring_empty |-> chosen_task == 4'd0)
        else $error("empty ring reports a task");

    a_empty_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ring_empty |-> status != ST_PRESENT)
        else $error("duplicate reported on empty ring");

    // one item in flight: drop ready right after an accepted beat
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

endmodule

bind round_robin_ready_ring_unit rrr_checker u_rrr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .task_req    (task_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .chosen_task (chosen_task),
    .ring_empty  (ring_empty),
    .status      (status)
);

`default_nettype wire

// ===== dv/round_robin_ready_ring_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_ready_ring_unit_tb: self-checking bench for the ready ring
// Directed beats walk the corner cases of clear, add, remove and next.
// Random beats follow in bursts with a varying add/remove balance, so the
// ring fills and drains. A scoreboard model predicts each result at input
// acceptance, and the monitor checks every output beat against it. Sender
// and receiver idle at random in two of three phases; the third has none.
// ----------------------------------------------------------------------------

module round_robin_ready_ring_unit_tb;

    import rrr_pkg::*;

    localparam int RING_TASKS = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] req;
    } ring_cmd_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] op = OP_CLEAR;
    logic [7:0] task_req = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] chosen_task;
    logic       ring_empty;
    logic [1:0] status;

    ring_cmd_t cmd_beats_q[$];
    rrr_res_t  ring_results_q[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // Scoreboard copy of the ring
    logic [3:0]            ring_link [RING_TASKS];
    logic [RING_TASKS-1:0] ring_member = '0;
    logic [3:0]            ring_tail = 4'd0;
    logic                  ring_is_empty = 1'b1;

    round_robin_ready_ring_unit #(
        .TASKS(RING_TASKS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .task_req   (task_req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .chosen_task(chosen_task),
        .ring_empty (ring_empty),
        .status     (status)
    );

    always #5 clk = ~clk;

    function automatic rrr_res_t ring_apply(input logic [1:0] cmd_op, input logic [7:0] req);
        rrr_res_t   res;
        logic [1:0] st;
        logic [3:0] id;
        logic [3:0] pred;
        st = ST_DONE;
        id = req[3:0];
        case (cmd_op)
            OP_CLEAR:
            begin
                ring_member = '0;
                ring_tail = 4'd0;
                ring_is_empty = 1'b1;
            end
            OP_ADD:
            begin
                if (req >= RING_TASKS)
                    st = ST_RANGE;
                else if (ring_member[id])
                    st = ST_PRESENT;
                else
                begin
                    if (ring_is_empty)
                    begin
                        ring_link[id] = id;
                        ring_is_empty = 1'b0;
                    end
                    else
                    begin
                        ring_link[id] = ring_link[ring_tail];
                        ring_link[ring_tail] = id;
                    end
                    ring_tail = id;
                    ring_member[id] = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (req >= RING_TASKS)
                    st = ST_RANGE;
                else if (ring_is_empty || !ring_member[id])
                    st = ST_ABSENT;
                else
                begin
                    ring_member[id] = 1'b0;
                    if (ring_link[id] == id)
                    begin
                        ring_tail = 4'd0;
                        ring_is_empty = 1'b1;
                    end
                    else
                    begin
                        // walk from the tail to the predecessor
                        pred = ring_tail;
                        while (ring_link[pred] != id)
                            pred = ring_link[pred];
                        ring_link[pred] = ring_link[id];
                        if (ring_tail == id)
                            ring_tail = pred;
                    end
                end
            end
            default:
            begin
                if (ring_is_empty)
                    st = ST_ABSENT;
                else
                    ring_tail = ring_link[ring_tail];
            end
        endcase
        res.chosen = ring_is_empty ? 4'd0 : ring_tail;
        res.empty = ring_is_empty;
        res.status = st;
        return res;
    endfunction

    function automatic void push_cmd(input logic [1:0] cmd_op, input logic [7:0] req);
        ring_cmd_t cmd;
        cmd.op = cmd_op;
        cmd.req = req;
        cmd_beats_q.push_back(cmd);
    endfunction

    // Bursts with a random add bias so the ring both fills up and drains
    function automatic void queue_random_cmds(input int count);
        int          add_pct;
        int unsigned roll;
        logic [7:0]  req;
        add_pct = 40;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                add_pct = $urandom_range(20, 65);
            roll = $urandom_range(99);
            if ($urandom_range(99) < 8)
                req = 8'($urandom_range(255));
            else
                req = 8'($urandom_range(RING_TASKS - 1));
            if (roll < 2)
                push_cmd(OP_CLEAR, 8'($urandom_range(255)));
            else if (roll < 2 + add_pct)
                push_cmd(OP_ADD, req);
            else if (roll < 2 + add_pct + (98 - add_pct) / 2)
                push_cmd(OP_REMOVE, req);
            else
                push_cmd(OP_NEXT, 8'($urandom_range(255)));
        end
    endfunction

    // Driver: predict on acceptance, then present the next beat or idle
    always @(posedge clk)
    begin
        ring_cmd_t cmd;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                ring_results_q.push_back(ring_apply(op, task_req));
            if (!in_valid || in_ready)
            begin
                if (cmd_beats_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd = cmd_beats_q.pop_front();
                    in_valid <= 1'b1;
                    op <= cmd.op;
                    task_req <= cmd.req;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each output beat against the oldest prediction
    always @(posedge clk)
    begin
        rrr_res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (ring_results_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected beat: chosen %0d empty %0d status %0d",
                                 chosen_task, ring_empty, status);
                end
                else
                begin
                    want = ring_results_q.pop_front();
                    if (chosen_task !== want.chosen || ring_empty !== want.empty ||
                        status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: chosen %0d/%0d empty %0d/%0d status %0d/%0d (exp/act)",
                                     want.chosen, chosen_task, want.empty, ring_empty,
                                     want.status, status);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic drain_ring();
        while (cmd_beats_q.size() != 0 || in_valid || ring_results_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        // empty ring corners, then adds, duplicates, range errors and steps
        push_cmd(OP_NEXT, 8'd0);
        push_cmd(OP_REMOVE, 8'd0);
        push_cmd(OP_REMOVE, 8'd255);
        push_cmd(OP_ADD, 8'd0);
        push_cmd(OP_ADD, 8'd0);
        push_cmd(OP_ADD, 8'd15);
        push_cmd(OP_ADD, 8'd7);
        push_cmd(OP_ADD, 8'd16);
        push_cmd(OP_ADD, 8'd255);
        push_cmd(OP_NEXT, 8'd255);
        push_cmd(OP_NEXT, 8'd0);
        push_cmd(OP_NEXT, 8'd0);
        // middle member, then the tail, then an absent one, then the last
        push_cmd(OP_REMOVE, 8'd15);
        push_cmd(OP_REMOVE, 8'd7);
        push_cmd(OP_REMOVE, 8'd3);
        push_cmd(OP_REMOVE, 8'd0);
        push_cmd(OP_ADD, 8'd5);
        push_cmd(OP_ADD, 8'd9);
        push_cmd(OP_CLEAR, 8'd255);
        push_cmd(OP_NEXT, 8'd0);
        push_cmd(OP_ADD, 8'd3);
        push_cmd(OP_REMOVE, 8'd3);
        push_cmd(OP_REMOVE, 8'd128);
        queue_random_cmds(570);

        send_idle_pct = 18;
        recv_idle_pct = 78;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        drain_ring();

        send_idle_pct = 78;
        recv_idle_pct = 18;
        queue_random_cmds(570);
        drain_ring();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_cmds(560);
        drain_ring();

        // hold off to catch any stray output beat
        repeat (RING_TASKS + 8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rrr_pkg.sv
hdl/rrr_ram.sv
hdl/rrr_seq.sv
hdl/round_robin_ready_ring_unit.sv
hdl/rrr_checker.sv
dv/round_robin_ready_ring_unit_tb.sv
